>>> rtl/css_pkg.sv
// css_pkg: shared types and constants of the charge stop sequencer
// item structs, configuration struct, register indexes, status bit positions
// no dependencies
package css_pkg;

    // input item
    typedef struct packed {
        logic        req_type;
        logic        battery_stop_seen;
        logic        battery_stats_seen;
        logic [15:0] module_current;
        logic [15:0] module_voltage;
        logic        gun_connected;
        logic [6:0]  fault_flags;
        logic [15:0] charge_minutes;
    } css_req_t;

    // result item
    typedef struct packed {
        logic        send_stop_msg;
        logic        send_stats_msg;
        logic        send_error_msg;
        logic        err_stop_timeout;
        logic        err_stats_timeout;
        logic [15:0] stats_minutes;
        logic        battery_power_on;
        logic        gun_lock_on;
        logic        open_contactors;
        logic        module_off;
        logic        stop_done;
    } css_res_t;

    // input register contents handed to the core
    typedef struct packed {
        logic     valid;
        css_req_t data;
    } css_stage_t;

    // configuration register file contents
    typedef struct packed {
        logic [15:0] stop_current_threshold;
        logic [15:0] discharge_voltage_threshold;
        logic [15:0] battery_stop_timeout;
        logic [15:0] battery_stats_timeout;
        logic [15:0] gun_loss_delay;
    } css_cfg_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CURRENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_VOLT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STATS_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUN_LOSS_DELAY = 3'd4;

    // register reset values
    localparam logic [15:0] RST_STOP_CURRENT   = 16'd50;
    localparam logic [15:0] RST_DISCHARGE_VOLT = 16'd600;
    localparam logic [15:0] RST_STOP_TIMEOUT   = 16'd5000;
    localparam logic [15:0] RST_STATS_TIMEOUT  = 16'd10000;
    localparam logic [15:0] RST_GUN_LOSS_DELAY = 16'd100;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // status bit positions
    localparam int SB_STOP_ERR  = 0;
    localparam int SB_STATS_ERR = 1;
    localparam int SB_END       = 2;
    localparam int SB_GUN_OUT   = 3;
    localparam int SB_POWER     = 4;
    localparam int SB_LOCK      = 5;
    localparam int SB_W         = 6;

    // timer slots
    localparam int T_STOP_MSG     = 0;
    localparam int T_STATS_MSG    = 1;
    localparam int T_ERROR_MSG    = 2;
    localparam int T_STOP_WAIT    = 3;
    localparam int T_STATS_WAIT   = 4;
    localparam int T_CURRENT_WAIT = 5;
    localparam int T_DISCHARGE    = 6;
    localparam int T_GUN_LOSS     = 7;
    localparam int NUM_TIMERS     = 8;

    // repeat counter
    localparam int          RC_W   = 4;
    localparam logic [3:0]  RC_MAX = 4'd15;

    // width used for the timer limit compares
    localparam int CMP_W = 33;

endpackage

>>> rtl/css_channels_if.sv
// css_channels_if: valid/ready channel interfaces for request and result items
// depends on css_pkg for the payload structs
interface css_req_if import css_pkg::*; ();
    logic     valid;
    logic     ready;
    css_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface css_res_if import css_pkg::*; ();
    logic     valid;
    logic     ready;
    css_res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/css_cfg_regs.sv
// css_cfg_regs: configuration register file of the charge stop sequencer
// depends on css_pkg for register indexes and reset values
module css_cfg_regs import css_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output css_cfg_t              cfg
);

    css_cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_current_threshold      <= RST_STOP_CURRENT;
            cfg_reg.discharge_voltage_threshold <= RST_DISCHARGE_VOLT;
            cfg_reg.battery_stop_timeout        <= RST_STOP_TIMEOUT;
            cfg_reg.battery_stats_timeout       <= RST_STATS_TIMEOUT;
            cfg_reg.gun_loss_delay              <= RST_GUN_LOSS_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_STOP_CURRENT:   cfg_reg.stop_current_threshold      <= cfg_data;
                CFG_DISCHARGE_VOLT: cfg_reg.discharge_voltage_threshold <= cfg_data;
                CFG_STOP_TIMEOUT:   cfg_reg.battery_stop_timeout        <= cfg_data;
                CFG_STATS_TIMEOUT:  cfg_reg.battery_stats_timeout       <= cfg_data;
                CFG_GUN_LOSS_DELAY: cfg_reg.gun_loss_delay              <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/css_input_stage.sv
// css_input_stage: input register in front of the sequencer core
// depends on css_pkg and css_channels_if
module css_input_stage import css_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    css_req_if.sink    req,
    input  logic       take,
    output css_stage_t stage
);

    logic     valid_reg;
    logic     valid_next;
    css_req_t data_reg;
    logic     load;

    // room when empty or when the held item moves on this cycle
    assign req.ready = !valid_reg || take;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= req.data;
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

>>> rtl/css_core.sv
// css_core: stop phase state, single pass step logic and result register
// depends on css_pkg and css_channels_if
module css_core import css_pkg::*;
#(
    parameter int STOP_MSG_PERIOD  = 8,
    parameter int REPEAT_PERIOD    = 250,
    parameter int REPEAT_LIMIT     = 5,
    parameter int CURRENT_WAIT_MAX = 120,
    parameter int DISCHARGE_MAX    = 4000,
    parameter int TIMER_WIDTH      = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  css_stage_t stage,
    input  css_cfg_t   cfg,
    output logic       take,
    css_res_if.source  res
);

    typedef struct packed {
        logic                   active;
        logic [TIMER_WIDTH-1:0] count;
    } tmr_t;

    localparam logic [CMP_W-1:0] LIM_STOP_MSG  = CMP_W'(STOP_MSG_PERIOD);
    localparam logic [CMP_W-1:0] LIM_REPEAT    = CMP_W'(REPEAT_PERIOD);
    localparam logic [CMP_W-1:0] LIM_CURRENT   = CMP_W'(CURRENT_WAIT_MAX);
    localparam logic [CMP_W-1:0] LIM_DISCHARGE = CMP_W'(DISCHARGE_MAX);
    localparam logic [RC_W-1:0]  LIM_REPEAT_N  = RC_W'(REPEAT_LIMIT);

    tmr_t            tmr_reg  [NUM_TIMERS];
    tmr_t            tmr_next [NUM_TIMERS];
    logic [RC_W-1:0] rc_reg;
    logic [RC_W-1:0] rc_next;
    logic [SB_W-1:0] sb_reg;
    logic [SB_W-1:0] sb_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    css_res_t        out_data_reg;
    css_res_t        out_data_next;
    logic            out_free;

    function automatic logic [CMP_W-1:0] ext16(input logic [15:0] v);
        ext16 = {{(CMP_W-16){1'b0}}, v};
    endfunction

    function automatic logic past(input tmr_t t, input logic [CMP_W-1:0] lim);
        past = t.active && ({{(CMP_W-TIMER_WIDTH){1'b0}}, t.count} > lim);
    endfunction

    // handshake: the item moves when the result register is free
    assign out_free = !out_valid_reg || res.ready;
    assign take     = stage.valid && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
    end

    // one step of the stop phase
    always_comb
    begin
        tmr_next      = tmr_reg;
        rc_next       = rc_reg;
        sb_next       = sb_reg;
        out_data_next = '0;

        if (stage.data.req_type == REQ_START)
        begin
            // arm the phase
            sb_next = '0;
            sb_next[SB_POWER] = 1'b1;
            sb_next[SB_LOCK]  = 1'b1;
            rc_next = '0;
            tmr_next[T_STOP_MSG]     = '{active: 1'b1, count: '0};
            tmr_next[T_STATS_MSG]    = '{active: 1'b0, count: '0};
            tmr_next[T_ERROR_MSG]    = '{active: 1'b0, count: '0};
            tmr_next[T_STOP_WAIT]    = '{active: !stage.data.battery_stop_seen, count: '0};
            tmr_next[T_STATS_WAIT]   = '{active: 1'b1, count: '0};
            tmr_next[T_CURRENT_WAIT] = '{active: 1'b1, count: '0};
            tmr_next[T_DISCHARGE]    = '{active: 1'b0, count: '0};
            tmr_next[T_GUN_LOSS]     = '{active: 1'b0, count: '0};
            out_data_next.send_stop_msg = 1'b1;
            out_data_next.module_off    = 1'b1;
        end
        else
        begin
            // advance every active timer, saturating
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                if (tmr_next[i].active && (tmr_next[i].count != {TIMER_WIDTH{1'b1}}))
                    tmr_next[i].count = tmr_next[i].count + 1'b1;
            end

            // stop message repeat
            if (past(tmr_next[T_STOP_MSG], LIM_STOP_MSG))
            begin
                out_data_next.send_stop_msg = 1'b1;
                tmr_next[T_STOP_MSG] = '{active: 1'b1, count: '0};
            end

            // statistics message repeat
            if (past(tmr_next[T_STATS_MSG], LIM_REPEAT))
            begin
                out_data_next.send_stats_msg = 1'b1;
                out_data_next.stats_minutes  = stage.data.charge_minutes;
                tmr_next[T_STATS_MSG] = '{active: 1'b1, count: '0};
                if (rc_next != RC_MAX)
                    rc_next = rc_next + 1'b1;
                if (rc_next > LIM_REPEAT_N)
                begin
                    sb_next[SB_POWER] = 1'b0;
                    tmr_next[T_STATS_MSG] = '{active: 1'b0, count: '0};
                end
            end

            // error message repeat, silent restart with no error bits
            if (past(tmr_next[T_ERROR_MSG], LIM_REPEAT))
            begin
                tmr_next[T_ERROR_MSG] = '{active: 1'b1, count: '0};
                if (sb_next[SB_STOP_ERR] || sb_next[SB_STATS_ERR])
                begin
                    out_data_next.send_error_msg = 1'b1;
                    if (rc_next != RC_MAX)
                        rc_next = rc_next + 1'b1;
                    if (rc_next > LIM_REPEAT_N)
                    begin
                        sb_next[SB_POWER] = 1'b0;
                        tmr_next[T_ERROR_MSG] = '{active: 1'b0, count: '0};
                    end
                end
            end

            // wait for battery stop message
            if (tmr_next[T_STOP_WAIT].active)
            begin
                if (stage.data.battery_stop_seen)
                begin
                    sb_next[SB_STOP_ERR] = 1'b0;
                    tmr_next[T_STOP_WAIT] = '{active: 1'b0, count: '0};
                end
                else if (ext16(cfg.battery_stop_timeout) <
                         {{(CMP_W-TIMER_WIDTH){1'b0}}, tmr_next[T_STOP_WAIT].count})
                begin
                    sb_next[SB_STOP_ERR] = 1'b1;
                    tmr_next[T_ERROR_MSG] = '{active: 1'b1, count: '0};
                    tmr_next[T_STOP_WAIT] = '{active: 1'b0, count: '0};
                end
            end

            // wait for battery statistics message
            if (tmr_next[T_STATS_WAIT].active)
            begin
                if (stage.data.battery_stats_seen)
                begin
                    sb_next[SB_STATS_ERR] = 1'b0;
                    tmr_next[T_STATS_MSG]  = '{active: 1'b1, count: '0};
                    tmr_next[T_STATS_WAIT] = '{active: 1'b0, count: '0};
                    tmr_next[T_STOP_MSG]   = '{active: 1'b0, count: '0};
                end
                else if (ext16(cfg.battery_stats_timeout) <
                         {{(CMP_W-TIMER_WIDTH){1'b0}}, tmr_next[T_STATS_WAIT].count})
                begin
                    if (!sb_next[SB_STOP_ERR])
                    begin
                        sb_next[SB_STATS_ERR] = 1'b1;
                        tmr_next[T_ERROR_MSG] = '{active: 1'b1, count: '0};
                    end
                    tmr_next[T_STATS_WAIT] = '{active: 1'b0, count: '0};
                    tmr_next[T_STOP_MSG]   = '{active: 1'b0, count: '0};
                end
            end

            // current fall, then open contactors and discharge
            if (tmr_next[T_CURRENT_WAIT].active &&
                ((stage.data.module_current < cfg.stop_current_threshold) ||
                 past(tmr_next[T_CURRENT_WAIT], LIM_CURRENT)))
            begin
                out_data_next.open_contactors = 1'b1;
                tmr_next[T_DISCHARGE]    = '{active: 1'b1, count: '0};
                tmr_next[T_CURRENT_WAIT] = '{active: 1'b0, count: '0};
            end

            // end of discharge
            if (tmr_next[T_DISCHARGE].active &&
                ((stage.data.module_voltage < cfg.discharge_voltage_threshold) ||
                 past(tmr_next[T_DISCHARGE], LIM_DISCHARGE)))
            begin
                sb_next[SB_END] = 1'b1;
                tmr_next[T_DISCHARGE] = '{active: 1'b0, count: '0};
            end

            // unlock and report done
            if (sb_next[SB_END] && (rc_next > LIM_REPEAT_N))
            begin
                sb_next[SB_LOCK] = 1'b0;
                if (sb_next[SB_GUN_OUT])
                    out_data_next.stop_done = 1'b1;
            end

            // gun withdrawal
            if (!stage.data.gun_connected)
            begin
                if (!tmr_next[T_GUN_LOSS].active)
                    tmr_next[T_GUN_LOSS] = '{active: 1'b1, count: '0};
            end
            else
            begin
                tmr_next[T_GUN_LOSS] = '{active: 1'b0, count: '0};
            end

            if (past(tmr_next[T_GUN_LOSS], ext16(cfg.gun_loss_delay)))
            begin
                out_data_next.module_off      = 1'b1;
                out_data_next.open_contactors = 1'b1;
                sb_next[SB_GUN_OUT] = 1'b1;
                tmr_next[T_GUN_LOSS] = '{active: 1'b0, count: '0};
            end

            // any fault forces power down
            if (stage.data.fault_flags != '0)
            begin
                out_data_next.module_off      = 1'b1;
                out_data_next.open_contactors = 1'b1;
            end
        end

        // levels from the updated status
        out_data_next.err_stop_timeout  = sb_next[SB_STOP_ERR];
        out_data_next.err_stats_timeout = sb_next[SB_STATS_ERR];
        out_data_next.battery_power_on  = sb_next[SB_POWER];
        out_data_next.gun_lock_on       = sb_next[SB_LOCK];
    end

    // state registers, updated once per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
                tmr_reg[i] <= '{active: 1'b0, count: '0};
            rc_reg        <= '0;
            sb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                tmr_reg <= tmr_next;
                rc_reg  <= rc_next;
                sb_reg  <= sb_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= out_data_next;
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

endmodule

>>> rtl/charge_stop_sequencer.sv
// charge_stop_sequencer: top level of the DC charger stop phase sequencer
// depends on css_pkg, css_channels_if, css_cfg_regs, css_input_stage, css_core
//
//   channel  direction  handshake          payload
//   req      in         valid/ready        css_req_t (start or tick item)
//   res      out        valid/ready        css_res_t (one result per item)
//   cfg      in         cfg_we, no ready   cfg_index, cfg_data
//
// one item per cycle sustained while res is ready; an accepted item sits in the input
// register until the result register is free, and its step then writes that register
// reset clears the valid bits, timers, repeat count and status bits and
// loads the register defaults; no clearing pass
// a stalled result holds the result register and, through it, the input
// register; the input takes a new item whenever its register is empty
module charge_stop_sequencer import css_pkg::*;
#(
    parameter int STOP_MSG_PERIOD  = 8,
    parameter int REPEAT_PERIOD    = 250,
    parameter int REPEAT_LIMIT     = 5,
    parameter int CURRENT_WAIT_MAX = 120,
    parameter int DISCHARGE_MAX    = 4000,
    parameter int TIMER_WIDTH      = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    css_req_if.sink               req,
    css_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    css_cfg_t   cfg;
    css_stage_t stage;
    logic       take;

    // configuration registers
    css_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    css_input_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .stage (stage)
    );

    // step logic and result register
    css_core #(
        .STOP_MSG_PERIOD  (STOP_MSG_PERIOD),
        .REPEAT_PERIOD    (REPEAT_PERIOD),
        .REPEAT_LIMIT     (REPEAT_LIMIT),
        .CURRENT_WAIT_MAX (CURRENT_WAIT_MAX),
        .DISCHARGE_MAX    (DISCHARGE_MAX),
        .TIMER_WIDTH      (TIMER_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .cfg   (cfg),
        .take  (take),
        .res   (res)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench of the charge stop sequencer
// drives start and tick items, predicts every result item and checks them in order
// depends on css_pkg, css_channels_if and the charge_stop_sequencer rtl
module tb;
    import css_pkg::*;

    localparam int STOP_MSG_PERIOD  = 8;
    localparam int REPEAT_PERIOD    = 250;
    localparam int REPEAT_LIMIT     = 5;
    localparam int CURRENT_WAIT_MAX = 120;
    localparam int DISCHARGE_MAX    = 4000;
    localparam int TIMER_WIDTH      = 16;
    localparam int CNT_MAX          = (1 << TIMER_WIDTH) - 1;

    localparam int NEVER        = 1 << 30;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_ITEMS = 530;
    localparam int LONG_TAIL    = 260;
    localparam int IDLE_PCT     = 30;
    localparam int TIMEOUT_NS   = 2_000_000;

    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef enum int
    {
        MODE_DEFAULTS,
        MODE_ALL_LOW,
        MODE_ALL_HIGH,
        MODE_FAST_TIMEOUTS,
        MODE_RANDOM
    } cfg_mode_t;

    // tick numbers at which the vehicle side moves on during one stop phase
    typedef struct {
        int len;
        int stop_ack_at;
        int stats_ack_at;
        int current_drop_at;
        int volt_drop_at;
        int gun_out_at;
        int fault_permille;
        int noise_pct;
    } phase_plan_t;

    // tracks the stop phase state and holds the result items still awaited
    class stop_phase_tracker;
        css_cfg_t        regs;
        bit              tmr_on [NUM_TIMERS];
        int              tmr_cnt [NUM_TIMERS];
        logic [RC_W-1:0] repeats;
        logic [SB_W-1:0] status;
        css_res_t        awaited_outputs [$];
        int              mismatches;

        function new();
            regs.stop_current_threshold      = RST_STOP_CURRENT;
            regs.discharge_voltage_threshold = RST_DISCHARGE_VOLT;
            regs.battery_stop_timeout        = RST_STOP_TIMEOUT;
            regs.battery_stats_timeout       = RST_STATS_TIMEOUT;
            regs.gun_loss_delay              = RST_GUN_LOSS_DELAY;
            for (int i = 0; i < NUM_TIMERS; i++)
                halt(i);
            repeats    = '0;
            status     = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            unique case (idx)
                CFG_STOP_CURRENT:   regs.stop_current_threshold      = val;
                CFG_DISCHARGE_VOLT: regs.discharge_voltage_threshold = val;
                CFG_STOP_TIMEOUT:   regs.battery_stop_timeout        = val;
                CFG_STATS_TIMEOUT:  regs.battery_stats_timeout       = val;
                CFG_GUN_LOSS_DELAY: regs.gun_loss_delay              = val;
                default: ;
            endcase
        endfunction

        function void arm(int t);
            tmr_on[t]  = 1'b1;
            tmr_cnt[t] = 0;
        endfunction

        function void halt(int t);
            tmr_on[t]  = 1'b0;
            tmr_cnt[t] = 0;
        endfunction

        function bit expired(int t, int lim);
            return tmr_on[t] && tmr_cnt[t] > lim;
        endfunction

        function void bump_repeats();
            if (repeats != RC_MAX)
                repeats++;
        endfunction

        function css_res_t next_outputs(css_req_t rq);
            css_res_t r;
            r = '0;
            if (rq.req_type == REQ_START)
            begin
                // arm the whole phase, no tick step
                status           = '0;
                status[SB_POWER] = 1'b1;
                status[SB_LOCK]  = 1'b1;
                repeats          = '0;
                arm(T_STOP_MSG);
                halt(T_STATS_MSG);
                halt(T_ERROR_MSG);
                if (rq.battery_stop_seen)
                    halt(T_STOP_WAIT);
                else
                    arm(T_STOP_WAIT);
                arm(T_STATS_WAIT);
                arm(T_CURRENT_WAIT);
                halt(T_DISCHARGE);
                halt(T_GUN_LOSS);
                r.send_stop_msg = 1'b1;
                r.module_off    = 1'b1;
            end
            else
            begin
                // advance active timers, saturating
                for (int i = 0; i < NUM_TIMERS; i++)
                    if (tmr_on[i] && tmr_cnt[i] < CNT_MAX)
                        tmr_cnt[i]++;

                // periodic messages
                if (expired(T_STOP_MSG, STOP_MSG_PERIOD))
                begin
                    r.send_stop_msg = 1'b1;
                    arm(T_STOP_MSG);
                end
                if (expired(T_STATS_MSG, REPEAT_PERIOD))
                begin
                    r.send_stats_msg = 1'b1;
                    r.stats_minutes  = rq.charge_minutes;
                    arm(T_STATS_MSG);
                    bump_repeats();
                    if (repeats > REPEAT_LIMIT)
                    begin
                        status[SB_POWER] = 1'b0;
                        halt(T_STATS_MSG);
                    end
                end
                if (expired(T_ERROR_MSG, REPEAT_PERIOD))
                begin
                    arm(T_ERROR_MSG);
                    // with no error bit the timer only restarts
                    if (status[SB_STOP_ERR] || status[SB_STATS_ERR])
                    begin
                        r.send_error_msg = 1'b1;
                        bump_repeats();
                        if (repeats > REPEAT_LIMIT)
                        begin
                            status[SB_POWER] = 1'b0;
                            halt(T_ERROR_MSG);
                        end
                    end
                end

                // battery message waits
                if (tmr_on[T_STOP_WAIT])
                begin
                    if (rq.battery_stop_seen)
                    begin
                        status[SB_STOP_ERR] = 1'b0;
                        halt(T_STOP_WAIT);
                    end
                    else if (tmr_cnt[T_STOP_WAIT] > regs.battery_stop_timeout)
                    begin
                        status[SB_STOP_ERR] = 1'b1;
                        arm(T_ERROR_MSG);
                        halt(T_STOP_WAIT);
                    end
                end
                if (tmr_on[T_STATS_WAIT])
                begin
                    if (rq.battery_stats_seen)
                    begin
                        status[SB_STATS_ERR] = 1'b0;
                        arm(T_STATS_MSG);
                        halt(T_STATS_WAIT);
                        halt(T_STOP_MSG);
                    end
                    else if (tmr_cnt[T_STATS_WAIT] > regs.battery_stats_timeout)
                    begin
                        if (!status[SB_STOP_ERR])
                        begin
                            status[SB_STATS_ERR] = 1'b1;
                            arm(T_ERROR_MSG);
                        end
                        halt(T_STATS_WAIT);
                        halt(T_STOP_MSG);
                    end
                end

                // current fall, then discharge
                if (tmr_on[T_CURRENT_WAIT] &&
                    (rq.module_current < regs.stop_current_threshold ||
                     tmr_cnt[T_CURRENT_WAIT] > CURRENT_WAIT_MAX))
                begin
                    r.open_contactors = 1'b1;
                    arm(T_DISCHARGE);
                    halt(T_CURRENT_WAIT);
                end
                if (tmr_on[T_DISCHARGE] &&
                    (rq.module_voltage < regs.discharge_voltage_threshold ||
                     tmr_cnt[T_DISCHARGE] > DISCHARGE_MAX))
                begin
                    status[SB_END] = 1'b1;
                    halt(T_DISCHARGE);
                end

                // unlock and finish
                if (status[SB_END] && repeats > REPEAT_LIMIT)
                begin
                    status[SB_LOCK] = 1'b0;
                    if (status[SB_GUN_OUT])
                        r.stop_done = 1'b1;
                end

                // gun withdrawal
                if (!rq.gun_connected)
                begin
                    if (!tmr_on[T_GUN_LOSS])
                        arm(T_GUN_LOSS);
                end
                else
                    halt(T_GUN_LOSS);
                if (expired(T_GUN_LOSS, regs.gun_loss_delay))
                begin
                    r.module_off      = 1'b1;
                    r.open_contactors = 1'b1;
                    status[SB_GUN_OUT] = 1'b1;
                    halt(T_GUN_LOSS);
                end

                if (rq.fault_flags != '0)
                begin
                    r.module_off      = 1'b1;
                    r.open_contactors = 1'b1;
                end
            end

            r.err_stop_timeout  = status[SB_STOP_ERR];
            r.err_stats_timeout = status[SB_STATS_ERR];
            r.battery_power_on  = status[SB_POWER];
            r.gun_lock_on       = status[SB_LOCK];
            return r;
        endfunction

        function void note_request(css_req_t rq);
            awaited_outputs.push_back(next_outputs(rq));
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_outputs(css_res_t got);
            css_res_t want;
            if (awaited_outputs.size() == 0)
            begin
                $error("result item with no request awaiting it");
                mismatches++;
                return;
            end
            want = awaited_outputs.pop_front();
            compare_field("send_stop_msg", 16'(want.send_stop_msg),
                          16'(got.send_stop_msg));
            compare_field("send_stats_msg", 16'(want.send_stats_msg),
                          16'(got.send_stats_msg));
            compare_field("send_error_msg", 16'(want.send_error_msg),
                          16'(got.send_error_msg));
            compare_field("err_stop_timeout", 16'(want.err_stop_timeout),
                          16'(got.err_stop_timeout));
            compare_field("err_stats_timeout", 16'(want.err_stats_timeout),
                          16'(got.err_stats_timeout));
            compare_field("stats_minutes", want.stats_minutes, got.stats_minutes);
            compare_field("battery_power_on", 16'(want.battery_power_on),
                          16'(got.battery_power_on));
            compare_field("gun_lock_on", 16'(want.gun_lock_on), 16'(got.gun_lock_on));
            compare_field("open_contactors", 16'(want.open_contactors),
                          16'(got.open_contactors));
            compare_field("module_off", 16'(want.module_off), 16'(got.module_off));
            compare_field("stop_done", 16'(want.stop_done), 16'(got.stop_done));
        endfunction

        function int pending();
            return awaited_outputs.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    css_cfg_t              live_cfg;
    int                    src_idle_pct = IDLE_PCT;
    int                    sink_stall_pct = IDLE_PCT;
    stop_phase_tracker     board;

    css_req_if req ();
    css_res_if res ();

    charge_stop_sequencer #(
        .STOP_MSG_PERIOD  (STOP_MSG_PERIOD),
        .REPEAT_PERIOD    (REPEAT_PERIOD),
        .REPEAT_LIMIT     (REPEAT_LIMIT),
        .CURRENT_WAIT_MAX (CURRENT_WAIT_MAX),
        .DISCHARGE_MAX    (DISCHARGE_MAX),
        .TIMER_WIDTH      (TIMER_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check accepted items, stall at random
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
                board.check_outputs(res.data);
            res.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // hand one item over, with a random gap in front
    task automatic send_request(input css_req_t rq);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        req.valid <= 1'b1;
        req.data  <= rq;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_request(rq);
    endtask

    // wait until every result item is in and the pipe is empty
    task automatic wait_idle();
        req.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_register(idx, val);
    endtask

    // write all registers back to back, plus one write to an unused index
    task automatic apply_config(input css_cfg_t c);
        logic [CFG_IDX_W-1:0] junk_idx;
        junk_idx = CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO));
        write_reg(CFG_STOP_CURRENT, c.stop_current_threshold);
        write_reg(CFG_DISCHARGE_VOLT, c.discharge_voltage_threshold);
        write_reg(CFG_STOP_TIMEOUT, c.battery_stop_timeout);
        write_reg(CFG_STATS_TIMEOUT, c.battery_stats_timeout);
        write_reg(CFG_GUN_LOSS_DELAY, c.gun_loss_delay);
        write_reg(junk_idx, 16'($urandom));
        cfg_we   <= 1'b0;
        live_cfg = c;
    endtask

    function automatic css_cfg_t pick_config(cfg_mode_t mode);
        css_cfg_t c;
        c.stop_current_threshold      = RST_STOP_CURRENT;
        c.discharge_voltage_threshold = RST_DISCHARGE_VOLT;
        c.battery_stop_timeout        = RST_STOP_TIMEOUT;
        c.battery_stats_timeout       = RST_STATS_TIMEOUT;
        c.gun_loss_delay              = RST_GUN_LOSS_DELAY;
        case (mode)
            MODE_ALL_LOW:
            begin
                c.stop_current_threshold      = '0;
                c.discharge_voltage_threshold = '0;
                c.battery_stop_timeout        = 16'd1;
                c.battery_stats_timeout       = 16'd1;
                c.gun_loss_delay              = 16'd1;
            end
            MODE_ALL_HIGH:
                c = '1;
            MODE_FAST_TIMEOUTS:
            begin
                c.stop_current_threshold      = 16'($urandom_range(1000, 0));
                c.discharge_voltage_threshold = 16'($urandom_range(2000, 0));
                c.battery_stop_timeout        = 16'($urandom_range(30, 1));
                c.battery_stats_timeout       = 16'($urandom_range(50, 1));
                c.gun_loss_delay              = 16'($urandom_range(15, 1));
            end
            MODE_RANDOM:
            begin
                c.stop_current_threshold      = 16'($urandom);
                c.discharge_voltage_threshold = 16'($urandom);
                c.battery_stop_timeout        = 16'($urandom_range(16'hFFFF, 1));
                c.battery_stats_timeout       = 16'($urandom_range(16'hFFFF, 1));
                c.gun_loss_delay              = 16'($urandom_range(16'hFFFF, 1));
            end
            default: ;
        endcase
        return c;
    endfunction

    // one tick of a stop phase; a few items are pure noise, starts included
    function automatic css_req_t make_tick(phase_plan_t p, int t);
        css_req_t    rq;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        rq = noise[$bits(css_req_t)-1:0];
        if ($urandom_range(99) < p.noise_pct)
            return rq;
        rq.req_type           = REQ_TICK;
        rq.battery_stop_seen  = (t >= p.stop_ack_at);
        rq.battery_stats_seen = (t >= p.stats_ack_at);
        if (t >= p.current_drop_at)
            rq.module_current = 16'($urandom_range(live_cfg.stop_current_threshold, 0));
        else
            rq.module_current = 16'($urandom_range(16'hFFFF,
                                                   live_cfg.stop_current_threshold));
        if (t >= p.volt_drop_at)
            rq.module_voltage = 16'($urandom_range(live_cfg.discharge_voltage_threshold, 0));
        else
            rq.module_voltage = 16'($urandom_range(16'hFFFF,
                                                   live_cfg.discharge_voltage_threshold));
        rq.gun_connected = (t < p.gun_out_at);
        if ($urandom_range(999) < p.fault_permille)
            rq.fault_flags = 7'($urandom_range(127, 1));
        else
            rq.fault_flags = '0;
        return rq;
    endfunction

    function automatic phase_plan_t short_plan();
        phase_plan_t p;
        if ($urandom_range(7) == 0)
            p.len = $urandom_range(320, 260);
        else
            p.len = $urandom_range(60, 5);
        p.stop_ack_at     = ($urandom_range(3) == 0) ? 0 : $urandom_range(p.len + 10, 1);
        p.stats_ack_at    = ($urandom_range(2) == 0) ? NEVER : $urandom_range(p.len + 10, 1);
        p.current_drop_at = $urandom_range(p.len, 1);
        p.volt_drop_at    = p.current_drop_at + $urandom_range(p.len, 0);
        p.gun_out_at      = $urandom_range(p.len + 5, p.len / 2);
        p.fault_permille  = ($urandom_range(3) == 0) ? 60 : 0;
        p.noise_pct       = 8;
        return p;
    endfunction

    // start item then the planned ticks
    task automatic run_phase(input phase_plan_t p);
        css_req_t    rq;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        rq = noise[$bits(css_req_t)-1:0];
        rq.req_type          = REQ_START;
        rq.battery_stop_seen = (p.stop_ack_at == 0);
        send_request(rq);
        for (int t = 1; t <= p.len; t++)
            send_request(make_tick(p, t));
    endtask

    // stimulus
    initial
    begin
        int          phase;
        int          random_sent;
        phase_plan_t plan;
        css_cfg_t    c;
        css_req_t    rq;

        board     = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        req.valid = 1'b0;
        req.data  = '0;
        live_cfg  = pick_config(MODE_DEFAULTS);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks before any start, field extremes
        rq = '0;
        rq.req_type = REQ_TICK;
        send_request(rq);
        rq = '1;
        rq.req_type = REQ_TICK;
        send_request(rq);

        // start with the battery stop already seen, then a normal start
        rq = '0;
        rq.req_type          = REQ_START;
        rq.battery_stop_seen = 1'b1;
        send_request(rq);
        rq = '1;
        rq.req_type          = REQ_START;
        rq.battery_stop_seen = 1'b0;
        send_request(rq);

        // each fault bit alone
        for (int k = 0; k < 7; k++)
        begin
            rq = '0;
            rq.req_type       = REQ_TICK;
            rq.module_current = '1;
            rq.module_voltage = '1;
            rq.gun_connected  = 1'b1;
            rq.fault_flags    = 7'(1 << k);
            send_request(rq);
        end

        // current and voltage fall, statistics seen, gun withdrawn
        rq.fault_flags       = '0;
        rq.battery_stop_seen = 1'b1;
        rq.module_current    = '0;
        send_request(rq);
        rq.module_voltage = '0;
        send_request(rq);
        rq.battery_stats_seen = 1'b1;
        rq.charge_minutes     = '1;
        send_request(rq);
        rq.gun_connected = 1'b0;
        repeat (3) send_request(rq);
        rq.req_type = REQ_START;
        send_request(rq);

        // stop phases, the first one long and with no idling at all
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if (phase == 0)
            begin
                // stop message times out, statistics acknowledged later,
                // so both the error and the statistics message repeat
                c = pick_config(MODE_DEFAULTS);
                c.battery_stop_timeout = 16'($urandom_range(20, 1));
                c.gun_loss_delay       = 16'($urandom_range(15, 1));
                apply_config(c);
                plan.stop_ack_at     = NEVER;
                plan.stats_ack_at    = $urandom_range(40, 25);
                plan.current_drop_at = $urandom_range(60, 10);
                plan.volt_drop_at    = plan.current_drop_at + $urandom_range(100, 0);
                plan.len             = plan.stats_ack_at + LONG_TAIL;
                plan.gun_out_at      = plan.len - int'(c.gun_loss_delay) - 5;
                plan.fault_permille  = 0;
                plan.noise_pct       = 0;
                src_idle_pct   = 0;
                sink_stall_pct = 0;
                run_phase(plan);
                src_idle_pct   = IDLE_PCT;
                sink_stall_pct = IDLE_PCT;
            end
            else
            begin
                if (phase == 1)
                    apply_config(pick_config(MODE_ALL_LOW));
                else if (phase == 2)
                    apply_config(pick_config(MODE_ALL_HIGH));
                else if ($urandom_range(3) != 0)
                    apply_config(pick_config(cfg_mode_t'($urandom_range(MODE_RANDOM,
                                                                        MODE_DEFAULTS))));
                plan = short_plan();
                if (plan.len > RANDOM_ITEMS - random_sent)
                    plan.len = RANDOM_ITEMS - random_sent;
                run_phase(plan);
            end
            random_sent += plan.len + 1;
            phase++;
        end

        wait_idle();
        if (board.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
